/* hdl/nhtt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nhtt_pkg
// shared codes and field widths for the node heartbeat timeout table
// ----------------------------------------------------------------------------
package nhtt_pkg;

  // item field widths
  localparam int CMD_W    = 2;
  localparam int NODE_W   = 3;
  localparam int TMO_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 8;

  // occupancy count, wide enough for the largest table
  localparam int CNT_W    = 4;

  // commands
  localparam logic [CMD_W-1:0] CMD_REGISTER  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

endpackage : nhtt_pkg
`default_nettype wire

/* hdl/nhtt_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nhtt_cmp
// shared elapsed-time unit: wrapping subtract and compare against a timeout
// ----------------------------------------------------------------------------
module nhtt_cmp #(
  parameter int TICK_BITS = 32
) (
  input  wire logic [TICK_BITS-1:0]       now_tick,
  input  wire logic [TICK_BITS-1:0]       seen_tick,
  input  wire logic [nhtt_pkg::TMO_W-1:0] tmo_limit,
  output logic                            expired
);
  import nhtt_pkg::*;

  localparam int CMP_W = (TICK_BITS > TMO_W) ? TICK_BITS : TMO_W;

  logic [TICK_BITS-1:0] elapsed;

  // modulo 2^TICK_BITS by construction of the subtract width
  assign elapsed = now_tick - seen_tick;

  // never-seen nodes do not time out
  assign expired = (seen_tick != '0) && (CMP_W'(elapsed) > CMP_W'(tmo_limit));

endmodule : nhtt_cmp
`default_nettype wire

/* hdl/node_heartbeat_timeout_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// node_heartbeat_timeout_table
// heartbeat monitor for up to eight nodes: register, heartbeat, check, query
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      in         in_valid / in_ready    cmd, node index, timeout, hb bytes, tick
//  out_     out        out_valid / out_ready  status, slot, masks, flags, query fields
//
// register, heartbeat and query: the item is captured, executed in S_EXEC, and
//   the result is loaded into the output register from S_DONE
// check: the sequencer steps from S_EXEC into S_WALK and walks the slots one
//   per cycle through the single elapsed-time compare unit, then makes the
//   end-of-walk test and moves to S_DONE
// in_ready is high only while the sequencer is idle; a finished result sits in
//   the output register so the next item can be taken while it waits
// a result that cannot be handed over holds the sequencer in its last step
// synchronous active-low reset clears the count, alive flags and sequencer
//
module node_heartbeat_timeout_table #(
  parameter int NODES     = 8,
  parameter int TICK_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [nhtt_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [nhtt_pkg::NODE_W-1:0]      in_node_index,
  input  wire logic [nhtt_pkg::TMO_W-1:0]       in_timeout_ticks,
  input  wire logic [nhtt_pkg::BYTE_W-1:0]      in_heartbeat_sequence,
  input  wire logic [nhtt_pkg::BYTE_W-1:0]      in_heartbeat_state,
  input  wire logic [nhtt_pkg::TICK_W-1:0]      in_now_tick,

  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [nhtt_pkg::STATUS_W-1:0]         out_status_code,
  output logic [nhtt_pkg::NODE_W-1:0]           out_assigned_node,
  output logic [nhtt_pkg::MASK_W-1:0]           out_timeout_mask,
  output logic                                  out_all_alive,
  output logic [nhtt_pkg::MASK_W-1:0]           out_lost_mask,
  output logic                                  out_regained,
  output logic                                  out_node_alive,
  output logic [nhtt_pkg::BYTE_W-1:0]           out_node_sequence,
  output logic [nhtt_pkg::BYTE_W-1:0]           out_node_state_byte,
  output logic [nhtt_pkg::TICK_W-1:0]           out_node_last_seen
);
  import nhtt_pkg::*;

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  // captured item
  logic [CMD_W-1:0]     cmd_r;
  logic [NODE_W-1:0]    idx_r;
  logic [TMO_W-1:0]     tmo_r;
  logic [BYTE_W-1:0]    seq_r;
  logic [BYTE_W-1:0]    stb_r;
  logic [TICK_BITS-1:0] now_r;

  // occupancy and walk counter
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;

  // node slots
  logic [TMO_W-1:0]     timeout_mem   [NODES];
  logic [TICK_BITS-1:0] last_seen_mem [NODES];
  logic [BYTE_W-1:0]    seq_mem       [NODES];
  logic [BYTE_W-1:0]    stb_mem       [NODES];
  logic [NODES-1:0]     alive_r;

  // result staging
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [NODE_W-1:0]   res_assigned_r, res_assigned_nxt;
  logic [MASK_W-1:0]   res_lost_r, res_lost_nxt;
  logic                res_regained_r, res_regained_nxt;
  logic                res_alive_r, res_alive_nxt;
  logic [BYTE_W-1:0]   res_seq_r, res_seq_nxt;
  logic [BYTE_W-1:0]   res_stb_r, res_stb_nxt;
  logic [TICK_W-1:0]   res_seen_r, res_seen_nxt;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [NODE_W-1:0]   out_assigned_r;
  logic [MASK_W-1:0]   out_tmask_r;
  logic                out_all_alive_r;
  logic [MASK_W-1:0]   out_lost_r;
  logic                out_regained_r;
  logic                out_alive_r;
  logic [BYTE_W-1:0]   out_seq_r;
  logic [BYTE_W-1:0]   out_stb_r;
  logic [TICK_W-1:0]   out_seen_r;

  logic in_fire, out_load;
  logic idx_ok, full, walk_live, expired;
  logic reg_wr, hb_wr, chk_clr;
  logic [IDX_W-1:0]     rd_addr, slot_addr;
  logic [TMO_W-1:0]     rd_timeout;
  logic [TICK_BITS-1:0] rd_last;
  logic                 rd_alive;
  logic [TICK_BITS-1:0] now_stamp;
  logic [MASK_W-1:0]    down_mask;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // addressed slot must lie below the registered count
  assign idx_ok    = ({1'b0, idx_r} < count_r);
  assign full      = (count_r >= CNT_W'(NODES));
  assign walk_live = (walk_r < count_r);

  // one read port: walk counter during a check, item index otherwise
  assign rd_addr    = (state_r == S_WALK) ? walk_r[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign slot_addr  = count_r[IDX_W-1:0];
  assign rd_timeout = timeout_mem[rd_addr];
  assign rd_last    = last_seen_mem[rd_addr];
  assign rd_alive   = alive_r[rd_addr];

  // tick 0 is stamped as 1, since 0 marks a node never seen
  assign now_stamp = (now_r == '0) ? TICK_BITS'(1) : now_r;

  nhtt_cmp #(
    .TICK_BITS (TICK_BITS)
  ) u_cmp (
    .now_tick  (now_r),
    .seen_tick (rd_last),
    .tmo_limit (rd_timeout),
    .expired   (expired)
  );

  assign reg_wr  = (state_r == S_EXEC) && (cmd_r == CMD_REGISTER) && !full;
  assign hb_wr   = (state_r == S_EXEC) && (cmd_r == CMD_HEARTBEAT) && idx_ok;
  assign chk_clr = (state_r == S_WALK) && walk_live && expired;

  // registered nodes that are not alive, after the command has taken effect
  always_comb begin
    down_mask = '0;
    for (int i = 0; i < NODES; i++) begin
      down_mask[i] = (CNT_W'(i) < count_r) && !alive_r[i];
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    walk_nxt         = walk_r;
    res_status_nxt   = res_status_r;
    res_assigned_nxt = res_assigned_r;
    res_lost_nxt     = res_lost_r;
    res_regained_nxt = res_regained_r;
    res_alive_nxt    = res_alive_r;
    res_seq_nxt      = res_seq_r;
    res_stb_nxt      = res_stb_r;
    res_seen_nxt     = res_seen_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt        = S_EXEC;
          res_status_nxt   = STAT_DONE;
          res_assigned_nxt = '0;
          res_lost_nxt     = '0;
          res_regained_nxt = 1'b0;
          res_alive_nxt    = 1'b0;
          res_seq_nxt      = '0;
          res_stb_nxt      = '0;
          res_seen_nxt     = '0;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_REGISTER: begin
            if (full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              res_assigned_nxt = count_r[NODE_W-1:0];
              count_nxt        = count_r + CNT_W'(1);
            end
          end
          CMD_HEARTBEAT: begin
            if (!idx_ok) begin
              res_status_nxt = STAT_IGNORED;
            end else begin
              // revived: seen before but currently down
              res_regained_nxt = !rd_alive && (rd_last != '0);
            end
          end
          CMD_CHECK: begin
            state_nxt = S_WALK;
            walk_nxt  = '0;
          end
          CMD_QUERY: begin
            if (!idx_ok) begin
              res_status_nxt = STAT_IGNORED;
            end else begin
              res_alive_nxt = rd_alive;
              res_seq_nxt   = seq_mem[rd_addr];
              res_stb_nxt   = stb_mem[rd_addr];
              res_seen_nxt  = TICK_W'(rd_last);
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        if (walk_live) begin
          if (expired && rd_alive) begin
            res_lost_nxt[walk_r[IDX_W-1:0]] = 1'b1;
          end
          walk_nxt = walk_r + CNT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
    end
  end

  // item capture, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      idx_r <= in_node_index;
      tmo_r <= in_timeout_ticks;
      seq_r <= in_heartbeat_sequence;
      stb_r <= in_heartbeat_state;
      now_r <= TICK_BITS'(in_now_tick);
    end
  end

  always_ff @(posedge clk) begin
    res_status_r   <= res_status_nxt;
    res_assigned_r <= res_assigned_nxt;
    res_lost_r     <= res_lost_nxt;
    res_regained_r <= res_regained_nxt;
    res_alive_r    <= res_alive_nxt;
    res_seq_r      <= res_seq_nxt;
    res_stb_r      <= res_stb_nxt;
    res_seen_r     <= res_seen_nxt;
  end

  // slot storage; a slot is cleared when it is registered
  always_ff @(posedge clk) begin
    if (reg_wr) begin
      timeout_mem[slot_addr]   <= tmo_r;
      last_seen_mem[slot_addr] <= '0;
      seq_mem[slot_addr]       <= '0;
      stb_mem[slot_addr]       <= '0;
    end else if (hb_wr) begin
      last_seen_mem[rd_addr] <= now_stamp;
      seq_mem[rd_addr]       <= seq_r;
      stb_mem[rd_addr]       <= stb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
    end else if (reg_wr) begin
      alive_r[slot_addr] <= 1'b0;
    end else if (hb_wr) begin
      alive_r[rd_addr] <= 1'b1;
    end else if (chk_clr) begin
      alive_r[rd_addr] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r    <= res_status_r;
      out_assigned_r  <= res_assigned_r;
      out_tmask_r     <= down_mask;
      out_all_alive_r <= (down_mask == '0);
      out_lost_r      <= res_lost_r;
      out_regained_r  <= res_regained_r;
      out_alive_r     <= res_alive_r;
      out_seq_r       <= res_seq_r;
      out_stb_r       <= res_stb_r;
      out_seen_r      <= res_seen_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status_code     = out_status_r;
  assign out_assigned_node   = out_assigned_r;
  assign out_timeout_mask    = out_tmask_r;
  assign out_all_alive       = out_all_alive_r;
  assign out_lost_mask       = out_lost_r;
  assign out_regained        = out_regained_r;
  assign out_node_alive      = out_alive_r;
  assign out_node_sequence   = out_seq_r;
  assign out_node_state_byte = out_stb_r;
  assign out_node_last_seen  = out_seen_r;

endmodule : node_heartbeat_timeout_table
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for node_heartbeat_timeout_table. An in-bench model of
// the slot table predicts one reply per accepted item. A directed table covers
// the empty table, never-seen nodes, ticks at zero and at wrap, regain and the
// full table. Random heartbeat, check and query traffic follows, run under
// several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import nhtt_pkg::*;

  localparam int NODES            = 8;
  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 475;
  localparam int DRAIN_CYCLES     = 16;      // a full check walk plus margin
  localparam int CYCLE_LIMIT      = 400000;

  // one item on the input channel
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node;
    logic [TMO_W-1:0]  timeout;
    logic [BYTE_W-1:0] hb_seq;
    logic [BYTE_W-1:0] hb_state;
    logic [TICK_W-1:0] now;
  } hb_item_t;

  // one item on the result channel
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   assigned;
    logic [MASK_W-1:0]   timeout_mask;
    logic                none_down;
    logic [MASK_W-1:0]   lost_mask;
    logic                regained;
    logic                alive;
    logic [BYTE_W-1:0]   seq;
    logic [BYTE_W-1:0]   state_byte;
    logic [TICK_W-1:0]   seen_tick;
  } hb_reply_t;

  // directed row: the reply is typed in only where it is obvious
  typedef struct packed {
    hb_item_t  item;
    logic      typed;
    hb_reply_t want;
  } stim_row_t;

  // clock, reset and channel signals; the bench-driven ones are known from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd = CMD_QUERY;
  logic [NODE_W-1:0]   in_node_index = '0;
  logic [TMO_W-1:0]    in_timeout_ticks = '0;
  logic [BYTE_W-1:0]   in_heartbeat_sequence = '0;
  logic [BYTE_W-1:0]   in_heartbeat_state = '0;
  logic [TICK_W-1:0]   in_now_tick = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status_code;
  logic [NODE_W-1:0]   out_assigned_node;
  logic [MASK_W-1:0]   out_timeout_mask;
  logic                out_all_alive;
  logic [MASK_W-1:0]   out_lost_mask;
  logic                out_regained;
  logic                out_node_alive;
  logic [BYTE_W-1:0]   out_node_sequence;
  logic [BYTE_W-1:0]   out_node_state_byte;
  logic [TICK_W-1:0]   out_node_last_seen;

  // bench copy of the slot table
  int                slots_used;
  logic [TMO_W-1:0]  slot_timeout   [NODES];
  logic [TICK_W-1:0] slot_last_seen [NODES];
  logic [BYTE_W-1:0] slot_seq       [NODES];
  logic [BYTE_W-1:0] slot_state     [NODES];
  logic              slot_alive     [NODES];

  hb_reply_t   replies_due [$];    // predicted replies, oldest first
  stim_row_t   directed_rows [$];
  logic [TICK_W-1:0] tick_counter = 32'd100;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          mismatch_seen  = 1'b0;
  int          cycle_count    = 0;

  node_heartbeat_timeout_table DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_node_index         (in_node_index),
    .in_timeout_ticks      (in_timeout_ticks),
    .in_heartbeat_sequence (in_heartbeat_sequence),
    .in_heartbeat_state    (in_heartbeat_state),
    .in_now_tick           (in_now_tick),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status_code       (out_status_code),
    .out_assigned_node     (out_assigned_node),
    .out_timeout_mask      (out_timeout_mask),
    .out_all_alive         (out_all_alive),
    .out_lost_mask         (out_lost_mask),
    .out_regained          (out_regained),
    .out_node_alive        (out_node_alive),
    .out_node_sequence     (out_node_sequence),
    .out_node_state_byte   (out_node_state_byte),
    .out_node_last_seen    (out_node_last_seen)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // bench state after reset: empty table, nobody alive
  initial begin
    slots_used = 0;
    for (int i = 0; i < NODES; i++) begin
      slot_timeout[i]   = '0;
      slot_last_seen[i] = '0;
      slot_seq[i]       = '0;
      slot_state[i]     = '0;
      slot_alive[i]     = 1'b0;
    end
  end

  // apply one command to the bench table and return the reply it gives
  function automatic hb_reply_t apply_command(input hb_item_t it);
    hb_reply_t         r;
    logic [TICK_W-1:0] elapsed;
    r = '0;
    case (it.cmd)
      CMD_REGISTER: begin
        if (slots_used >= NODES) begin
          r.status = STAT_FULL;
        end else begin
          slot_timeout[slots_used]   = it.timeout;
          slot_last_seen[slots_used] = '0;
          slot_seq[slots_used]       = '0;
          slot_state[slots_used]     = '0;
          slot_alive[slots_used]     = 1'b0;
          r.assigned = slots_used[NODE_W-1:0];
          slots_used++;
        end
      end
      CMD_HEARTBEAT: begin
        if (it.node >= slots_used) begin
          r.status = STAT_IGNORED;
        end else begin
          // a revival only counts for a node that was seen before
          r.regained = !slot_alive[it.node] && (slot_last_seen[it.node] != '0);
          // tick zero is kept for never seen, so stamp it as one
          slot_last_seen[it.node] = (it.now == '0) ? TICK_W'(1) : it.now;
          slot_seq[it.node]       = it.hb_seq;
          slot_state[it.node]     = it.hb_state;
          slot_alive[it.node]     = 1'b1;
        end
      end
      CMD_CHECK: begin
        for (int i = 0; i < NODES; i++) begin
          if (i < slots_used) begin
            elapsed = it.now - slot_last_seen[i];   // wraps with the tick
            if (slot_last_seen[i] != '0 && elapsed > slot_timeout[i]) begin
              if (slot_alive[i]) r.lost_mask[i] = 1'b1;
              slot_alive[i] = 1'b0;
            end
          end
        end
      end
      default: begin
        if (it.node >= slots_used) begin
          r.status = STAT_IGNORED;
        end else begin
          r.alive      = slot_alive[it.node];
          r.seq        = slot_seq[it.node];
          r.state_byte = slot_state[it.node];
          r.seen_tick  = slot_last_seen[it.node];
        end
      end
    endcase
    // masks reflect the table after the command
    for (int i = 0; i < NODES; i++) begin
      if (i < slots_used && !slot_alive[i]) r.timeout_mask[i] = 1'b1;
    end
    r.none_down = (r.timeout_mask == '0);
    return r;
  endfunction

  function automatic hb_item_t mk_item(input logic [CMD_W-1:0] cmd,
                                       input logic [NODE_W-1:0] node,
                                       input logic [TMO_W-1:0] timeout,
                                       input logic [BYTE_W-1:0] hb_seq,
                                       input logic [BYTE_W-1:0] hb_state,
                                       input logic [TICK_W-1:0] now);
    hb_item_t it;
    it.cmd      = cmd;
    it.node     = node;
    it.timeout  = timeout;
    it.hb_seq   = hb_seq;
    it.hb_state = hb_state;
    it.now      = now;
    return it;
  endfunction

  // typed reply for a row that neither loses nor regains a node
  function automatic hb_reply_t mk_reply(input logic [STATUS_W-1:0] status,
                                         input logic [NODE_W-1:0] assigned,
                                         input logic [MASK_W-1:0] mask,
                                         input logic none_down,
                                         input logic alive,
                                         input logic [BYTE_W-1:0] seq,
                                         input logic [BYTE_W-1:0] state_byte,
                                         input logic [TICK_W-1:0] seen_tick);
    hb_reply_t r;
    r              = '0;
    r.status       = status;
    r.assigned     = assigned;
    r.timeout_mask = mask;
    r.none_down    = none_down;
    r.alive        = alive;
    r.seq          = seq;
    r.state_byte   = state_byte;
    r.seen_tick    = seen_tick;
    return r;
  endfunction

  task automatic add_row(input hb_item_t it, input logic typed, input hb_reply_t want);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // random traffic: mostly heartbeats, checks and queries on a slowly moving tick
  function automatic hb_item_t random_item();
    hb_item_t it;
    int       pick;
    it.cmd      = CMD_QUERY;
    it.node     = NODE_W'($urandom_range(NODES - 1));
    it.timeout  = $urandom;
    it.hb_seq   = BYTE_W'($urandom);
    it.hb_state = BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 3)       it.cmd = CMD_REGISTER;    // table is full by now
    else if (pick < 43) it.cmd = CMD_HEARTBEAT;
    else if (pick < 73) it.cmd = CMD_CHECK;
    // small steps keep short timeouts alive, bigger ones let them lapse
    pick = $urandom_range(99);
    if (pick < 70)      tick_counter = tick_counter + $urandom_range(4);
    else if (pick < 95) tick_counter = tick_counter + $urandom_range(60, 5);
    else if (pick < 98) tick_counter = $urandom;
    else                tick_counter = 32'hFFFF_FFF0 + $urandom_range(15);
    it.now = tick_counter;
    // now and then a heartbeat lands on tick zero
    if (it.cmd == CMD_HEARTBEAT && $urandom_range(49) == 0) it.now = '0;
    return it;
  endfunction

  // offer one item, wait for the handshake, then log the reply it should give
  task automatic send_item(input hb_item_t it, input logic typed, input hb_reply_t want);
    hb_reply_t model_reply;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_cmd                <= it.cmd;
    in_node_index         <= it.node;
    in_timeout_ticks      <= it.timeout;
    in_heartbeat_sequence <= it.hb_seq;
    in_heartbeat_state    <= it.hb_state;
    in_now_tick           <= it.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_reply = apply_command(it);
    replies_due.push_back(typed ? want : model_reply);
  endtask

  // hold the sender off until every outstanding reply is back
  task automatic wait_all_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_seen = 1'b1;
      $display("%0t: %s expected 'h%0h, actual 'h%0h", $time, name, want, got);
    end
  endtask

  // stimulus
  initial begin
    // empty table: query and heartbeat are ignored, and nothing is down
    add_row(mk_item(CMD_QUERY, 3'd0, '0, 8'h00, 8'h00, 32'd0), 1'b1,
            mk_reply(STAT_IGNORED, 3'd0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0));
    add_row(mk_item(CMD_HEARTBEAT, 3'd7, '0, 8'hAA, 8'h55, 32'd100), 1'b1,
            mk_reply(STAT_IGNORED, 3'd0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0));
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'd0), 1'b1,
            mk_reply(STAT_DONE, 3'd0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0));
    // first node, zero timeout, starts down and never seen
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'd0, 8'h00, 8'h00, 32'd0), 1'b1,
            mk_reply(STAT_DONE, 3'd0, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0));
    add_row(mk_item(CMD_QUERY, 3'd0, '0, 8'h00, 8'h00, 32'd0), 1'b1,
            mk_reply(STAT_DONE, 3'd0, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0));
    // never seen: a check at the largest tick leaves it alone
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'hFFFF_FFFF), 1'b1,
            mk_reply(STAT_DONE, 3'd0, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 32'd0));
    // heartbeat on tick zero is stamped as one
    add_row(mk_item(CMD_HEARTBEAT, 3'd0, '0, 8'hFF, 8'hFF, 32'd0), 1'b1,
            mk_reply(STAT_DONE, 3'd0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0));
    add_row(mk_item(CMD_QUERY, 3'd0, '0, 8'h00, 8'h00, 32'd0), 1'b1,
            mk_reply(STAT_DONE, 3'd0, 8'h00, 1'b1, 1'b1, 8'hFF, 8'hFF, 32'd1));
    // elapsed equal to the timeout survives, one more tick loses the node
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'd1), 1'b0, '0);
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'd2), 1'b0, '0);
    // regain of a node seen before
    add_row(mk_item(CMD_HEARTBEAT, 3'd0, '0, 8'h00, 8'h00, 32'd5), 1'b0, '0);
    // slot just past the registered count
    add_row(mk_item(CMD_HEARTBEAT, 3'd1, '0, 8'h12, 8'h34, 32'd7), 1'b0, '0);
    // largest timeout with a heartbeat on the largest tick
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_HEARTBEAT, 3'd1, '0, 8'h5A, 8'hA5, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_item(CMD_QUERY, 3'd1, '0, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'hFFFF_FFFE), 1'b0, '0);
    // tick wrap: elapsed 10 stays, elapsed 11 lapses
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'd10, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_HEARTBEAT, 3'd2, '0, 8'h01, 8'h80, 32'hFFFF_FFF8), 1'b0, '0);
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'd2), 1'b0, '0);
    add_row(mk_item(CMD_CHECK, 3'd0, '0, 8'h00, 8'h00, 32'd3), 1'b0, '0);
    // fill the rest, then one more for the full table
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'd3, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'h8000_0000, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'd1000, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'd100, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'd50, 8'h00, 8'h00, 32'd0), 1'b0, '0);
    add_row(mk_item(CMD_REGISTER, 3'd0, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'd0), 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end
    wait_all_replies();

    // idling mixes: none, sender only, receiver only, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        send_item(random_item(), 1'b0, '0);
      end
      wait_all_replies();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random back-pressure, compare each reply with the oldest prediction
  always @(posedge clk) begin : reply_check
    hb_reply_t got;
    hb_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status       = out_status_code;
      got.assigned     = out_assigned_node;
      got.timeout_mask = out_timeout_mask;
      got.none_down    = out_all_alive;
      got.lost_mask    = out_lost_mask;
      got.regained     = out_regained;
      got.alive        = out_node_alive;
      got.seq          = out_node_sequence;
      got.state_byte   = out_node_state_byte;
      got.seen_tick    = out_node_last_seen;
      if (replies_due.size() == 0) begin
        mismatch_seen = 1'b1;
        $display("%0t: reply expected none, actual status 'h%0h", $time, got.status);
      end else begin
        want = replies_due.pop_front();
        check_field("status",          want.status,       got.status);
        check_field("assigned_node",   want.assigned,     got.assigned);
        check_field("timeout_mask",    want.timeout_mask, got.timeout_mask);
        check_field("out_all_alive",   want.none_down,    got.none_down);
        check_field("lost_mask",       want.lost_mask,    got.lost_mask);
        check_field("regained",        want.regained,     got.regained);
        check_field("node_alive",      want.alive,        got.alive);
        check_field("node_sequence",   want.seq,          got.seq);
        check_field("node_state_byte", want.state_byte,   got.state_byte);
        check_field("node_last_seen",  want.seen_tick,    got.seen_tick);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
